### rtl/core/bql_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bql_pkg;

  localparam int unsigned NUM_COEFS = 5;
  localparam int unsigned CFG_INDEX_WIDTH = 3;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t CFG_B0 = 3'd0;
  localparam cfg_index_t CFG_B1 = 3'd1;
  localparam cfg_index_t CFG_B2 = 3'd2;
  localparam cfg_index_t CFG_A1 = 3'd3;
  localparam cfg_index_t CFG_A2 = 3'd4;

endpackage

`default_nettype wire

### rtl/core/biquad_lowpass_filter_unit.sv
// A request accepted on sample_in goes to the input register; its result is loaded into
// the result register (sample_out) when that register is empty or not stalled.
// Throughput: one sample per cycle while not stalled; limited by the feedback path from
// the output delay line via the coefficient multipliers, adder, rounding, saturation.
// Reset (rst, synchronous, active high) sets b0 to unity and the other coefficients
// to zero, clears both delay lines and empties the input and output registers.
`timescale 1ns / 1ps
`default_nettype none

module biquad_lowpass_filter_unit #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned COEF_FRAC_BITS = 16,
  parameter int unsigned COEF_WIDTH     = COEF_FRAC_BITS + 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire bql_pkg::cfg_index_t            cfg_index,
  input  wire logic        [COEF_WIDTH-1:0]   cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed      [SAMPLE_WIDTH-1:0] sample_out,
  output logic                                clipped
);
  import bql_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic signed [SAMPLE_WIDTH-1:0] input_delay_one, input_delay_two;
  logic signed [SAMPLE_WIDTH-1:0] output_delay_one, output_delay_two;
  logic signed [SAMPLE_WIDTH-1:0] y_next;
  logic                           clip_next;
  logic                           advance;
  logic                           compute;

  bql_coef_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .COEF_WIDTH     (COEF_WIDTH)
  ) u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_b0   (coef_b0),
    .coef_b1   (coef_b1),
    .coef_b2   (coef_b2),
    .coef_a1   (coef_a1),
    .coef_a2   (coef_a2)
  );

  bql_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .COEF_WIDTH     (COEF_WIDTH)
  ) u_mac (
    .x0      (s1_sample),
    .x1      (input_delay_one),
    .x2      (input_delay_two),
    .y1      (output_delay_one),
    .y2      (output_delay_two),
    .coef_b0 (coef_b0),
    .coef_b1 (coef_b1),
    .coef_b2 (coef_b2),
    .coef_a1 (coef_a1),
    .coef_a2 (coef_a2),
    .y       (y_next),
    .clip    (clip_next)
  );

  assign advance  = !out_valid || !out_stall;
  assign compute  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample_in;
    end
  end

  // delay lines
  always_ff @(posedge clk) begin
    if (rst) begin
      input_delay_one  <= '0;
      input_delay_two  <= '0;
      output_delay_one <= '0;
      output_delay_two <= '0;
    end else if (compute) begin
      input_delay_two  <= input_delay_one;
      input_delay_one  <= s1_sample;
      output_delay_two <= output_delay_one;
      output_delay_one <= y_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (compute) begin
      sample_out <= y_next;
      clipped    <= clip_next;
    end
  end

  a_compute_fills_output: assert property (@(posedge clk) disable iff (rst)
    compute |=> out_valid)
    else $error("computed sample did not reach the output register");

  a_input_delay_shift: assert property (@(posedge clk) disable iff (rst)
    compute |=> (input_delay_one == $past(s1_sample)))
    else $error("input delay line did not take the processed sample");

  a_output_delay_matches: assert property (@(posedge clk) disable iff (rst)
    compute |=> (output_delay_one == sample_out))
    else $error("output delay line differs from the delivered sample");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == SMAX || sample_out == SMIN))
    else $error("clipped sample is not at a rail");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline could advance");

endmodule

`default_nettype wire

### rtl/core/bql_coef_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bql_coef_regs #(
  parameter int unsigned COEF_FRAC_BITS = 16,
  parameter int unsigned COEF_WIDTH     = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire bql_pkg::cfg_index_t          cfg_index,
  input  wire logic        [COEF_WIDTH-1:0] cfg_data,
  output logic signed      [COEF_WIDTH-1:0] coef_b0,
  output logic signed      [COEF_WIDTH-1:0] coef_b1,
  output logic signed      [COEF_WIDTH-1:0] coef_b2,
  output logic signed      [COEF_WIDTH-1:0] coef_a1,
  output logic signed      [COEF_WIDTH-1:0] coef_a2
);
  import bql_pkg::*;

  localparam logic signed [COEF_WIDTH-1:0] UNITY = COEF_WIDTH'(1) << COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= UNITY;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_B0:  coef_b0 <= cfg_data;
        CFG_B1:  coef_b1 <= cfg_data;
        CFG_B2:  coef_b2 <= cfg_data;
        CFG_A1:  coef_a1 <= cfg_data;
        CFG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/bql_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module bql_mac #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned COEF_FRAC_BITS = 16,
  parameter int unsigned COEF_WIDTH     = 18
) (
  input  wire logic signed [SAMPLE_WIDTH-1:0] x0,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x1,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x2,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y1,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y2,
  input  wire logic signed [COEF_WIDTH-1:0]   coef_b0,
  input  wire logic signed [COEF_WIDTH-1:0]   coef_b1,
  input  wire logic signed [COEF_WIDTH-1:0]   coef_b2,
  input  wire logic signed [COEF_WIDTH-1:0]   coef_a1,
  input  wire logic signed [COEF_WIDTH-1:0]   coef_a2,
  output logic signed      [SAMPLE_WIDTH-1:0] y,
  output logic                                clip
);

  localparam int unsigned PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned ACC_WIDTH  = PROD_WIDTH + 3;
  localparam int unsigned RND_WIDTH  = ACC_WIDTH - COEF_FRAC_BITS;
  localparam logic signed [ACC_WIDTH-1:0] ROUND = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PROD_WIDTH-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [RND_WIDTH-1:0]  rounded;
  logic [RND_WIDTH-SAMPLE_WIDTH:0] top_bits;
  logic pos_ovf, neg_ovf;

  always_comb begin
    p_b0 = PROD_WIDTH'(coef_b0) * PROD_WIDTH'(x0);
    p_b1 = PROD_WIDTH'(coef_b1) * PROD_WIDTH'(x1);
    p_b2 = PROD_WIDTH'(coef_b2) * PROD_WIDTH'(x2);
    p_a1 = PROD_WIDTH'(coef_a1) * PROD_WIDTH'(y1);
    p_a2 = PROD_WIDTH'(coef_a2) * PROD_WIDTH'(y2);

    acc = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
        - ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2) + ROUND;

    rounded  = acc[ACC_WIDTH-1:COEF_FRAC_BITS];
    top_bits = rounded[RND_WIDTH-1:SAMPLE_WIDTH-1];
    pos_ovf  = !rounded[RND_WIDTH-1] && (|top_bits);
    neg_ovf  = rounded[RND_WIDTH-1] && !(&top_bits);

    clip = pos_ovf || neg_ovf;
    if (pos_ovf) begin
      y = SMAX;
    end else if (neg_ovf) begin
      y = SMIN;
    end else begin
      y = rounded[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bql_pkg::*;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS = 16;
  localparam int COEF_WIDTH = FRAC_BITS + 2;
  localparam int STUCK_LIMIT = 2000;
  localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = 18'sh1FFFF;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = 18'sh20000;
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = 18'sh10000;
  localparam logic signed [COEF_WIDTH-1:0] COEF_HALF = 18'sh08000;
  localparam cfg_index_t CFG_SPARE_FIRST = CFG_A2 + 3'd1;
  localparam cfg_index_t CFG_SPARE_LAST = 3'd7;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           clip;
  } filtered_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_B0;
  logic [COEF_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic clipped;

  logic signed [COEF_WIDTH-1:0] coef_b0 = COEF_ONE;
  logic signed [COEF_WIDTH-1:0] coef_b1 = '0;
  logic signed [COEF_WIDTH-1:0] coef_b2 = '0;
  logic signed [COEF_WIDTH-1:0] coef_a1 = '0;
  logic signed [COEF_WIDTH-1:0] coef_a2 = '0;
  logic signed [SAMPLE_WIDTH-1:0] x_d1, x_d2, y_d1, y_d2;

  logic signed [SAMPLE_WIDTH-1:0] pending_samples[$];
  filtered_t expected_out[$];
  logic in_taken = 1'b0;
  logic bursts_on = 1'b1;
  int in_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;

  biquad_lowpass_filter_unit #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .clipped   (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic filtered_t filter_step(input logic signed [SAMPLE_WIDTH-1:0] x);
    filtered_t res;
    longint acc;
    acc = longint'(coef_b0) * longint'(x) + longint'(coef_b1) * longint'(x_d1)
        + longint'(coef_b2) * longint'(x_d2) - longint'(coef_a1) * longint'(y_d1)
        - longint'(coef_a2) * longint'(y_d2);
    acc = (acc + ROUND_HALF) >>> FRAC_BITS;
    res.clip = 1'b1;
    if (acc > longint'(SAMPLE_MAX)) begin
      res.sample = SAMPLE_MAX;
    end else if (acc < longint'(SAMPLE_MIN)) begin
      res.sample = SAMPLE_MIN;
    end else begin
      res.sample = SAMPLE_WIDTH'(acc);
      res.clip = 1'b0;
    end
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = res.sample;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input int unsigned kind);
    case (kind)
      0: return SAMPLE_WIDTH'($urandom);
      1: return SAMPLE_WIDTH'(int'($urandom_range(0, 1023)) - 512);
      default: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    endcase
  endfunction

  // request driver
  always @(negedge clk) begin
    logic send;
    send = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 12);
      end else if (pending_samples.size() != 0) begin
        send = 1'b1;
      end
      if (send) begin
        sample_in <= pending_samples.pop_front();
      end
      in_valid <= send;
    end
  end

  // result-side stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    filtered_t want;
    logic in_acc;
    logic out_acc;
    in_acc = in_valid && !in_stall;
    out_acc = out_valid && !out_stall;
    if (rst) begin
      in_taken <= 1'b0;
      quiet_cycles <= 0;
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
    end else begin
      in_taken <= in_acc;
      quiet_cycles <= (in_acc || out_acc) ? 0 : quiet_cycles + 1;
      if (in_acc) begin
        expected_out.push_back(filter_step(sample_in));
      end
      if (out_acc) begin
        if (expected_out.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: result with none expected: sample_out %0d clipped %0b",
                   $time, sample_out, clipped);
        end else begin
          want = expected_out.pop_front();
          if (sample_out !== want.sample || clipped !== want.clip) begin
            errors <= errors + 1;
            $display("%0t: mismatch: expected sample_out %0d clipped %0b, got %0d %0b",
                     $time, want.sample, want.clip, sample_out, clipped);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STUCK_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic write_coef(input cfg_index_t idx, input logic [COEF_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_B0: coef_b0 = $signed(value);
      CFG_B1: coef_b1 = $signed(value);
      CFG_B2: coef_b2 = $signed(value);
      CFG_A1: coef_a1 = $signed(value);
      CFG_A2: coef_a2 = $signed(value);
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(input logic [COEF_WIDTH-1:0] b0, b1, b2, a1, a2);
    write_coef(CFG_B0, b0);
    write_coef(CFG_B1, b1);
    write_coef(CFG_B2, b2);
    write_coef(CFG_A1, a1);
    write_coef(CFG_A2, a2);
    close_writes();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    #1;
    while (pending_samples.size() != 0 || in_valid || expected_out.size() != 0) begin
      @(negedge clk);
      #1;
    end
  endtask

  task automatic push_segments(input int count);
    int n;
    int unsigned kind;
    int unsigned len;
    logic signed [SAMPLE_WIDTH-1:0] level;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 3);
      len = $urandom_range(1, 20);
      level = pick_sample(0);
      repeat (len) begin
        pending_samples.push_back(kind == 3 ? level : pick_sample(kind));
        n++;
      end
    end
  endtask

  initial begin : stimulus
    int num_phases;
    num_phases = 13;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unity pass-through after reset
    pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, -16'sd1, 16'sd1, 16'sh5555};
    wait_idle();

    // writes to unused indexes must not land
    write_coef(CFG_SPARE_FIRST, COEF_MAX);
    write_coef(CFG_SPARE_LAST, COEF_MIN);
    close_writes();
    pending_samples = '{16'sd1234, -16'sd4321};
    wait_idle();

    // saturation at both rails
    load_coefs(COEF_MAX, '0, '0, '0, '0);
    pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd1};
    wait_idle();
    load_coefs(COEF_MIN, '0, '0, '0, '0);
    pending_samples = '{SAMPLE_MIN, SAMPLE_MAX};
    wait_idle();

    // rounding of exact halves
    load_coefs(COEF_HALF, '0, '0, '0, '0);
    pending_samples = '{16'sd1, -16'sd1, -16'sd3};
    wait_idle();

    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    pending_samples = '{SAMPLE_MIN, SAMPLE_MAX};
    wait_idle();
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    pending_samples = '{SAMPLE_MAX, SAMPLE_MIN};
    wait_idle();

    // integrator: saturated output feeds back
    load_coefs(COEF_ONE, '0, '0, -COEF_ONE, '0);
    pending_samples = '{16'sd30000, 16'sd30000, SAMPLE_MIN};
    wait_idle();

    for (int phase = 0; phase < num_phases; phase++) begin
      bursts_on = (phase != num_phases - 1) && ($urandom_range(0, 3) != 0);
      case (phase % 4)
        0: load_coefs(18'(4425 + $urandom_range(0, 200)), 18'(8850), 18'(4425),
                      18'(-74907), 18'(27053));
        1: load_coefs(18'($urandom), 18'($urandom), 18'($urandom),
                      18'($urandom), 18'($urandom));
        2: load_coefs(18'(int'($urandom_range(0, 65535)) - 32768),
                      18'(int'($urandom_range(0, 65535)) - 32768),
                      18'(int'($urandom_range(0, 65535)) - 32768),
                      18'(int'($urandom_range(0, 65535)) - 32768),
                      18'(int'($urandom_range(0, 65535)) - 32768));
        default: begin
          repeat ($urandom_range(1, 4))
            write_coef(cfg_index_t'($urandom_range(0, 7)), 18'($urandom));
          close_writes();
        end
      endcase
      push_segments(105);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
